// ===== hw/rtl/rma_pkg.sv =====
// Shared types, opcodes and constants of the register machine ALU.
`default_nettype none

package rma_pkg;

   localparam int DATA_W           = 64;
   localparam int OP_W             = 4;
   localparam int REG_FIELD_W      = 2;
   localparam int CNT_W            = $clog2(DATA_W);
   localparam int DEFAULT_NUM_REGS = 4;

   typedef enum logic [OP_W-1:0] {
      OP_LDI  = 4'd0,
      OP_MOV  = 4'd1,
      OP_ADD  = 4'd2,
      OP_SUB  = 4'd3,
      OP_MUL  = 4'd4,
      OP_DIV  = 4'd5,
      OP_MOD  = 4'd6,
      OP_AND  = 4'd7,
      OP_OR   = 4'd8,
      OP_XOR  = 4'd9,
      OP_XCHG = 4'd10,
      OP_OUT  = 4'd11
   } rma_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RDA,
      ST_RDB,
      ST_CAPB,
      ST_EXEC,
      ST_MUL,
      ST_DIVPRE,
      ST_DIV,
      ST_DIVFIX,
      ST_WRD,
      ST_WRA,
      ST_RESP
   } rma_state_type;

   typedef struct packed {
      logic [OP_W-1:0]        req_type;
      logic [REG_FIELD_W-1:0] dest_reg;
      logic [REG_FIELD_W-1:0] src_a;
      logic [REG_FIELD_W-1:0] src_b;
      logic signed [DATA_W-1:0] immediate;
   } rma_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     status;
   } rma_rsp_type;

   // Sequencer strobes to the datapath
   typedef struct packed {
      logic busy;
      logic accept;
      logic rd_a;
      logic rd_b;
      logic cap_b;
      logic exec;
      logic mul_step;
      logic div_pre;
      logic div_step;
      logic div_fix;
      logic wr_d;
      logic wr_a;
      logic resp_load;
   } rma_ctrl_type;

   // Datapath status back to the sequencer
   typedef struct packed {
      logic            req_valid;
      logic [OP_W-1:0] new_op;
      logic [OP_W-1:0] op;
      logic            div_zero;
      logic            last_iter;
      logic            rsp_free;
   } rma_stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/register_machine_alu_core.sv =====
// Top level of the register machine ALU: datapath around the shared adder.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   rma_req_type
//   rsp       out        rsp_valid/rsp_stall   rma_rsp_type
//
// One instruction at a time; req_stall is high until it has finished.
// Multiply and divide/modulo iterate one bit per cycle through the single
// 64-bit adder; divide/modulo skip the iteration on a zero divisor.
// Register reads go through one port.
// Reset clears the sequencer, the output valid bit and all register valid bits.
// A result waits in the output register; an output instruction finding it
// still full holds until rsp_stall drops.
`default_nettype none

module register_machine_alu_core
   import rma_pkg::*;
#(
   parameter int NUM_REGS = DEFAULT_NUM_REGS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire rma_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rma_rsp_type      rsp_data
);

   localparam int IDX_W      = $clog2(NUM_REGS);
   localparam int RAW_SPAN   = 1 << REG_FIELD_W;
   localparam bit NREG_WRAPS = (NUM_REGS < RAW_SPAN);
   localparam int NREG_MOD   = NUM_REGS % RAW_SPAN;

   function automatic logic [IDX_W-1:0] reg_index(input logic [REG_FIELD_W-1:0] raw);
      logic [REG_FIELD_W-1:0] r;
      r = raw;
      // Raw field stays below twice the register count: one subtract folds it
      if (NREG_WRAPS && r >= REG_FIELD_W'(NREG_MOD)) begin
         r = r - REG_FIELD_W'(NREG_MOD);
      end
      return IDX_W'(r);
   endfunction

   rma_ctrl_type ctrl;
   rma_stat_type stat;

   logic [OP_W-1:0]   op_ff,    op_in;
   logic [IDX_W-1:0]  d_idx_ff, d_idx_in;
   logic [IDX_W-1:0]  a_idx_ff, a_idx_in;
   logic [IDX_W-1:0]  b_idx_ff, b_idx_in;
   logic [DATA_W-1:0] opa_ff,   opa_in;
   logic [DATA_W-1:0] opb_ff,   opb_in;
   logic [DATA_W-1:0] acc_ff,   acc_in;
   logic [DATA_W-1:0] aux_ff,   aux_in;
   logic [CNT_W-1:0]  cnt_ff,   cnt_in;
   logic              neg_a_ff, neg_a_in;
   logic              neg_b_ff, neg_b_in;
   rma_rsp_type       rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [DATA_W-1:0] add_x;
   logic [DATA_W-1:0] add_y;
   logic              add_sub;
   logic [DATA_W-1:0] add_sum;
   logic              add_carry;

   logic              rf_wr_en;
   logic [IDX_W-1:0]  rf_wr_addr;
   logic [DATA_W-1:0] rf_wr_data;
   logic [IDX_W-1:0]  rf_rd_addr;
   logic [DATA_W-1:0] rf_rd_data;

   logic [DATA_W-1:0] div_shift;
   logic [DATA_W-1:0] fix_val;
   logic              fix_neg;
   logic              is_div;

   rma_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   rma_addsub u_addsub (
      .x     (add_x),
      .y     (add_y),
      .sub   (add_sub),
      .sum   (add_sum),
      .carry (add_carry)
   );

   rma_regfile #(
      .NUM_REGS (NUM_REGS),
      .IDX_W    (IDX_W)
   ) u_regfile (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rf_wr_en),
      .wr_addr (rf_wr_addr),
      .wr_data (rf_wr_data),
      .rd_addr (rf_rd_addr),
      .rd_data (rf_rd_data)
   );

   assign is_div    = (op_ff == OP_DIV) || (op_ff == OP_MOD);
   assign div_shift = {acc_ff[DATA_W-2:0], aux_ff[DATA_W-1]};
   assign fix_val   = (op_ff == OP_DIV) ? aux_ff : acc_ff;
   assign fix_neg   = (op_ff == OP_DIV) ? (neg_a_ff ^ neg_b_ff) : neg_a_ff;

   always_comb begin
      stat.req_valid = req_valid;
      stat.new_op    = req_data.req_type;
      stat.op        = op_ff;
      stat.div_zero  = (opb_ff == '0);
      stat.last_iter = (cnt_ff == CNT_W'(DATA_W - 1));
      stat.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign req_stall = ctrl.busy;

   // Shared adder operand selection
   always_comb begin
      add_x   = opa_ff;
      add_y   = opb_ff;
      add_sub = 1'b0;
      priority if (ctrl.exec) begin
         if (op_ff == OP_SUB) begin
            add_sub = 1'b1;
         end else if (is_div) begin
            add_x   = '0;
            add_y   = opa_ff;
            add_sub = 1'b1;
         end
      end else if (ctrl.mul_step) begin
         add_x = acc_ff;
         add_y = opa_ff;
      end else if (ctrl.div_pre) begin
         add_x   = '0;
         add_y   = opb_ff;
         add_sub = 1'b1;
      end else if (ctrl.div_step) begin
         add_x   = div_shift;
         add_y   = opb_ff;
         add_sub = 1'b1;
      end else if (ctrl.div_fix) begin
         add_x   = '0;
         add_y   = fix_val;
         add_sub = 1'b1;
      end else begin
         add_sub = 1'b0;
      end
   end

   // Register file access
   always_comb begin
      rf_rd_addr = a_idx_ff;
      if (ctrl.rd_b) begin
         rf_rd_addr = (op_ff == OP_XCHG || op_ff == OP_OUT) ? d_idx_ff : b_idx_ff;
      end
      rf_wr_en   = ctrl.wr_d || ctrl.wr_a;
      rf_wr_addr = ctrl.wr_a ? a_idx_ff : d_idx_ff;
      rf_wr_data = ctrl.wr_a ? opb_ff : acc_ff;
   end

   // Datapath next values
   always_comb begin
      op_in    = op_ff;
      d_idx_in = d_idx_ff;
      a_idx_in = a_idx_ff;
      b_idx_in = b_idx_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      acc_in   = acc_ff;
      aux_in   = aux_ff;
      cnt_in   = cnt_ff;
      neg_a_in = neg_a_ff;
      neg_b_in = neg_b_ff;

      if (ctrl.accept) begin
         op_in    = req_data.req_type;
         d_idx_in = reg_index(req_data.dest_reg);
         a_idx_in = reg_index(req_data.src_a);
         b_idx_in = reg_index(req_data.src_b);
         acc_in   = req_data.immediate;
      end

      if (ctrl.rd_b) begin
         opa_in = rf_rd_data;
      end

      if (ctrl.cap_b) begin
         opb_in = rf_rd_data;
      end

      if (ctrl.exec) begin
         unique case (op_ff)
            OP_ADD, OP_SUB:  acc_in = add_sum;
            OP_AND:          acc_in = opa_ff & opb_ff;
            OP_OR:           acc_in = opa_ff | opb_ff;
            OP_XOR:          acc_in = opa_ff ^ opb_ff;
            OP_MOV, OP_XCHG: acc_in = opa_ff;
            OP_MUL: begin
               acc_in = '0;
               aux_in = opb_ff;
               cnt_in = '0;
            end
            OP_DIV, OP_MOD: begin
               // Take the dividend magnitude and remember both signs
               neg_a_in = opa_ff[DATA_W-1];
               neg_b_in = opb_ff[DATA_W-1];
               opa_in   = opa_ff[DATA_W-1] ? add_sum : opa_ff;
            end
            default:         acc_in = acc_ff;
         endcase
      end

      if (ctrl.mul_step) begin
         acc_in = aux_ff[0] ? add_sum : acc_ff;
         opa_in = {opa_ff[DATA_W-2:0], 1'b0};
         aux_in = {1'b0, aux_ff[DATA_W-1:1]};
         cnt_in = cnt_ff + CNT_W'(1);
      end

      if (ctrl.div_pre) begin
         opb_in = opb_ff[DATA_W-1] ? add_sum : opb_ff;
         acc_in = '0;
         aux_in = opa_ff;
         cnt_in = '0;
      end

      // Restoring step: keep the difference when the trial subtract does not borrow
      if (ctrl.div_step) begin
         acc_in = add_carry ? add_sum : div_shift;
         aux_in = {aux_ff[DATA_W-2:0], add_carry};
         cnt_in = cnt_ff + CNT_W'(1);
      end

      if (ctrl.div_fix) begin
         acc_in = fix_neg ? add_sum : fix_val;
      end
   end

   // Output register
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctrl.resp_load) begin
         rsp_data_in.value  = is_div ? '0 : opb_ff;
         rsp_data_in.status = is_div;
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      d_idx_ff    <= d_idx_in;
      a_idx_ff    <= a_idx_in;
      b_idx_ff    <= b_idx_in;
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      acc_ff      <= acc_in;
      aux_ff      <= aux_in;
      cnt_ff      <= cnt_in;
      neg_a_ff    <= neg_a_in;
      neg_b_ff    <= neg_b_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rma_addsub.sv =====
// Shared 64-bit adder/subtractor with carry out.
`default_nettype none

module rma_addsub
   import rma_pkg::*;
(
   input  wire logic [DATA_W-1:0] x,
   input  wire logic [DATA_W-1:0] y,
   input  wire logic              sub,
   output logic [DATA_W-1:0]      sum,
   output logic                   carry
);

   logic [DATA_W-1:0] y_eff;

   assign y_eff = sub ? ~y : y;
   assign {carry, sum} = {1'b0, x} + {1'b0, y_eff} + (DATA_W+1)'(sub);

endmodule

`default_nettype wire

// ===== hw/rtl/rma_regfile.sv =====
// Register file: one write port, one registered read port, valid bits for reset.
`default_nettype none

module rma_regfile
   import rma_pkg::*;
#(
   parameter int NUM_REGS = DEFAULT_NUM_REGS,
   parameter int IDX_W    = $clog2(NUM_REGS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [IDX_W-1:0]  wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [IDX_W-1:0]  rd_addr,
   output logic [DATA_W-1:0]      rd_data
);

   logic [DATA_W-1:0]   mem_ff [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff;
   logic [NUM_REGS-1:0] valid_in;
   logic [DATA_W-1:0]   rd_data_ff;
   logic                rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff  <= mem_ff[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   // An entry never written since reset reads as zero
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/rma_ctrl.sv =====
// Sequencer that steps one instruction through read, execute, iterate and write or respond.
`default_nettype none

module rma_ctrl
   import rma_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire rma_stat_type stat,
   output rma_ctrl_type      ctrl
);

   rma_state_type state_ff;
   rma_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (stat.req_valid) begin
               if (stat.new_op == OP_LDI) begin
                  state_in = ST_WRD;
               end else if (stat.new_op > OP_OUT) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RDA;
               end
            end
         end
         ST_RDA:  state_in = ST_RDB;
         ST_RDB:  state_in = ST_CAPB;
         ST_CAPB: state_in = ST_EXEC;
         ST_EXEC: begin
            priority if (stat.op == OP_MUL) begin
               state_in = ST_MUL;
            end else if (stat.op == OP_DIV || stat.op == OP_MOD) begin
               state_in = stat.div_zero ? ST_RESP : ST_DIVPRE;
            end else if (stat.op == OP_OUT) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_WRD;
            end
         end
         ST_MUL: begin
            if (stat.last_iter) begin
               state_in = ST_WRD;
            end
         end
         ST_DIVPRE: state_in = ST_DIV;
         ST_DIV: begin
            if (stat.last_iter) begin
               state_in = ST_DIVFIX;
            end
         end
         ST_DIVFIX: state_in = ST_WRD;
         ST_WRD:    state_in = (stat.op == OP_XCHG) ? ST_WRA : ST_IDLE;
         ST_WRA:    state_in = ST_IDLE;
         ST_RESP: begin
            if (stat.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE:   ctrl.accept    = stat.req_valid;
         ST_RDA:    ctrl.rd_a      = 1'b1;
         ST_RDB:    ctrl.rd_b      = 1'b1;
         ST_CAPB:   ctrl.cap_b     = 1'b1;
         ST_EXEC:   ctrl.exec      = 1'b1;
         ST_MUL:    ctrl.mul_step  = 1'b1;
         ST_DIVPRE: ctrl.div_pre   = 1'b1;
         ST_DIV:    ctrl.div_step  = 1'b1;
         ST_DIVFIX: ctrl.div_fix   = 1'b1;
         ST_WRD:    ctrl.wr_d      = 1'b1;
         ST_WRA:    ctrl.wr_a      = 1'b1;
         ST_RESP:   ctrl.resp_load = stat.rsp_free;
         default:   ctrl.accept    = 1'b0;
      endcase
      ctrl.busy = (state_ff != ST_IDLE);
   end

endmodule

`default_nettype wire

// ===== tb/tb_register_machine_alu_core.sv =====
// Self-checking testbench for the register machine ALU: directed and random instruction streams.
`timescale 1ns / 1ps

module tb_register_machine_alu_core;
   import rma_pkg::*;

   localparam int          NUM_REGS       = DEFAULT_NUM_REGS;
   localparam int          OP_CODES       = 1 << OP_W;
   localparam int          RANDOM_ITEMS   = 400;
   localparam int          PRESSURE_AT    = 20;
   localparam int          PRESSURE_HOLD  = 400;
   localparam int          DRAIN_CYCLES   = 150;
   localparam int          WATCHDOG_LIMIT = 3000;
   localparam logic [63:0] MIN_VAL        = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX_VAL        = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] ALL_ONES       = 64'hFFFF_FFFF_FFFF_FFFF;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   rma_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rma_rsp_type rsp_data;

   rma_req_type instr_q[$];
   rma_rsp_type expected_outputs[$];
   logic [63:0] reg_file[NUM_REGS];

   int items_sent    = 0;
   int results_seen  = 0;
   int gap_left      = 0;
   int stall_left    = 0;
   int idle_cycles   = 0;
   int error_count   = 0;
   bit pressure_done = 1'b0;

   wire quiet_span = (items_sent >= 150) && (items_sent < 230);
   wire req_fire   = req_valid && !req_stall;
   wire rsp_fire   = rsp_valid && !rsp_stall;

   register_machine_alu_core #(
      .NUM_REGS(NUM_REGS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #4 clock = ~clock;

   // Apply one instruction to the register file and queue any result it gives
   function automatic void execute_instr(rma_req_type ins);
      logic [63:0] va, vb, mag_a, mag_b, quo, rem, held;
      int unsigned d, a, b;
      rma_rsp_type res;
      d = ins.dest_reg % NUM_REGS;
      a = ins.src_a % NUM_REGS;
      b = ins.src_b % NUM_REGS;
      va = reg_file[a];
      vb = reg_file[b];
      case (ins.req_type)
         OP_LDI: reg_file[d] = ins.immediate;
         OP_MOV: reg_file[d] = va;
         OP_ADD: reg_file[d] = va + vb;
         OP_SUB: reg_file[d] = va - vb;
         OP_MUL: reg_file[d] = va * vb;
         OP_DIV, OP_MOD: begin
            if (vb == 64'd0) begin
               res.value  = '0;
               res.status = 1'b1;
               expected_outputs.push_back(res);
            end else begin
               // divide magnitudes unsigned, then restore the signs
               mag_a = va[63] ? 64'd0 - va : va;
               mag_b = vb[63] ? 64'd0 - vb : vb;
               quo = mag_a / mag_b;
               rem = mag_a % mag_b;
               if (va[63] != vb[63]) quo = 64'd0 - quo;
               if (va[63]) rem = 64'd0 - rem;
               reg_file[d] = (ins.req_type == OP_DIV) ? quo : rem;
            end
         end
         OP_AND: reg_file[d] = va & vb;
         OP_OR:  reg_file[d] = va | vb;
         OP_XOR: reg_file[d] = va ^ vb;
         OP_XCHG: begin
            held = reg_file[d];
            reg_file[d] = va;
            reg_file[a] = held;
         end
         OP_OUT: begin
            res.value  = reg_file[d];
            res.status = 1'b0;
            expected_outputs.push_back(res);
         end
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [63:0] random_operand();
      logic [63:0]        full;
      logic signed [63:0] wide;
      int                 near_zero;
      int unsigned        roll;
      full = {$urandom, $urandom};
      wide = full;
      roll = $urandom_range(0, 99);
      near_zero = int'($urandom_range(0, 40)) - 20;
      if (roll < 40) return full;
      if (roll < 60) begin
         wide = near_zero;
         return wide;
      end
      if (roll < 75) begin
         case ($urandom_range(0, 4))
            0: return MIN_VAL;
            1: return MAX_VAL;
            2: return ALL_ONES;
            3: return 64'd0;
            default: return 64'd1;
         endcase
      end
      return wide >>> $urandom_range(1, 62);
   endfunction

   task automatic issue(logic [OP_W-1:0] op, int d, int a, int b, logic [63:0] imm);
      rma_req_type ins;
      ins.req_type  = op;
      ins.dest_reg  = REG_FIELD_W'(d);
      ins.src_a     = REG_FIELD_W'(a);
      ins.src_b     = REG_FIELD_W'(b);
      ins.immediate = imm;
      instr_q.push_back(ins);
   endtask

   task automatic issue_random();
      int unsigned roll;
      logic [OP_W-1:0] op;
      roll = $urandom_range(0, 99);
      if (roll < 18)      op = OP_LDI;
      else if (roll < 22) op = OP_MOV;
      else if (roll < 30) op = roll[0] ? OP_ADD : OP_SUB;
      else if (roll < 38) op = OP_MUL;
      else if (roll < 54) op = roll[0] ? OP_DIV : OP_MOD;
      else if (roll < 57) op = OP_AND;
      else if (roll < 60) op = OP_OR;
      else if (roll < 62) op = OP_XOR;
      else if (roll < 66) op = OP_XCHG;
      else if (roll < 94) op = OP_OUT;
      else                op = OP_W'($urandom_range(OP_OUT + 1, OP_CODES - 1));
      issue(op, $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
            (op == OP_LDI) ? random_operand() : {$urandom, $urandom});
   endtask

   // Driver: present queued instructions, hold while stalled, idle a random gap (possibly none) between them
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_fire) begin
            execute_instr(req_data);
            items_sent <= items_sent + 1;
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left  <= gap_left - 1;
            end else if (instr_q.size() > 0) begin
               req_valid <= 1'b1;
               req_data  <= instr_q.pop_front();
               gap_left  <= quiet_span ? 0 : pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result transaction against the oldest expectation
   always @(posedge clock) begin
      rma_rsp_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_fire) begin
            results_seen <= results_seen + 1;
            if (expected_outputs.size() == 0) begin
               $display("%0t: unexpected result value=%h status=%b",
                        $time, rsp_data.value, rsp_data.status);
               error_count++;
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_data.value !== want.value) begin
                  $display("%0t: value mismatch expected=%h actual=%h",
                           $time, want.value, rsp_data.value);
                  error_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status mismatch expected=%b actual=%b",
                           $time, want.status, rsp_data.status);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (!pressure_done && results_seen >= PRESSURE_AT) begin
            // hold off long enough for a waiting result to back up the input
            rsp_stall     <= 1'b1;
            stall_left    <= PRESSURE_HOLD;
            pressure_done <= 1'b1;
         end else if (!quiet_span && $urandom_range(0, 7) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= pick_gap();
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: end the run if no transaction moves for too long
   always @(posedge clock) begin
      if (reset || req_fire || rsp_fire) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, no transaction for %0d cycles", $time, idle_cycles);
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < NUM_REGS; i++) reg_file[i] = '0;

      // extremes and the minimum over minus one case
      issue(OP_LDI, 0, 0, 0, MIN_VAL);
      issue(OP_LDI, 1, 0, 0, ALL_ONES);
      issue(OP_LDI, 2, 0, 0, MAX_VAL);
      issue(OP_LDI, 3, 0, 0, 64'd0);
      issue(OP_DIV, 3, 0, 1, '0);
      issue(OP_OUT, 3, 0, 0, '0);
      issue(OP_MOD, 3, 0, 1, '0);
      issue(OP_OUT, 3, 0, 0, '0);
      // divide and modulo by zero
      issue(OP_DIV, 2, 0, 3, '0);
      issue(OP_MOD, 1, 1, 3, '0);
      // wrapping arithmetic
      issue(OP_ADD, 3, 2, 2, '0);
      issue(OP_MUL, 3, 3, 2, '0);
      issue(OP_SUB, 3, 3, 0, '0);
      issue(OP_OUT, 3, 0, 0, '0);
      issue(OP_XOR, 3, 3, 1, '0);
      issue(OP_AND, 3, 3, 2, '0);
      issue(OP_OR,  3, 3, 0, '0);
      issue(OP_OUT, 3, 0, 0, '0);
      issue(OP_MOV, 1, 2, 0, '0);
      issue(OP_XCHG, 0, 1, 0, '0);
      issue(OP_XCHG, 2, 2, 3, '0);
      // unused opcode with every field bit set: ignored
      issue(OP_W'(OP_CODES - 1), 3, 3, 3, ALL_ONES);
      issue(OP_OUT, 0, 0, 0, '0);
      issue(OP_OUT, 1, 0, 0, '0);

      for (int i = 0; i < RANDOM_ITEMS; i++) issue_random();
      issue(OP_OUT, 2, 0, 0, '0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (instr_q.size() > 0 || req_valid) @(posedge clock);
      while (expected_outputs.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_outputs.size() > 0)
         $display("%0t: %0d expected results never arrived", $time, expected_outputs.size());
      if (error_count == 0 && expected_outputs.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/rma_pkg.sv
hw/rtl/rma_addsub.sv
hw/rtl/rma_regfile.sv
hw/rtl/rma_ctrl.sv
hw/rtl/register_machine_alu_core.sv
tb/tb_register_machine_alu_core.sv
